// File: design/bis_pkg.sv
// Package for the bitmap integer set: field widths, opcodes and the
// command and status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package bis_pkg;

	// Number of 32-bit words in the bitmap, used as the default depth.
	localparam int WORD_COUNT_DEFAULT = 128;

	localparam int WORD_W     = 32;
	localparam int BIT_SEL_W  = 5;
	localparam int ELEM_W     = 16;
	localparam int WORD_IDX_W = ELEM_W - BIT_SEL_W;
	localparam int COUNT_W    = 13;
	localparam int OP_W       = 2;

	typedef enum logic [OP_W-1:0] {
		OP_TEST   = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} bis_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;      // latch the input word and start the word read
		logic sweep_start; // rewind the clearing address
		logic sweep_step;  // zero one word and advance the clearing address
		logic commit;      // write back the word, update count, load result
	} bis_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_is_clear; // the offered input word is a clear
		logic sweep_last;  // the clearing address is at the last word
	} bis_status_t;

endpackage

// File: design/bitmap_integer_set.sv
// Top level of the bitmap integer set.
// Depends on bis_pkg, bis_ctrl and bis_dp (which holds bis_ram).
`timescale 1ns / 1ps

// Usage
// The input channel takes one word per accepted handshake (in_valid high,
// in_stall low): an opcode (test, add, remove, clear) and a 16-bit element.
// The element selects bit element mod 32 of bitmap word element/32. Every
// input word produces exactly one result word on the output channel:
// was_member, the member count after the operation, and out_of_range.
// Test, add and remove read the bitmap word from the RAM when the word is
// accepted; at commit, once the output register is free, an add or remove
// that changes the word writes it back and the result is loaded. No new
// word is taken until the last one has committed; the RAM's single
// read-modify-write per word sets that pace. A clear zeroes the words
// one a cycle. After reset the same clearing pass runs with in_stall
// high; the running member count and output valid reset at once.
// A result waits in the output register while the receiver stalls; the
// next input word is still accepted, and its result is held back until
// the register is free.
module bitmap_integer_set #(
	parameter int WORD_COUNT = bis_pkg::WORD_COUNT_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bis_pkg::OP_W-1:0]    opcode,
	input  logic [bis_pkg::ELEM_W-1:0]  element,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        was_member,
	output logic [bis_pkg::COUNT_W-1:0] member_count,
	output logic                        out_of_range
);

	// Commands and status that join the controller and the datapath.
	bis_pkg::bis_cmd_t    cmd;
	bis_pkg::bis_status_t status;

	// The controller sequences the reset sweep, accepts input words and
	// decides when a result may be loaded into the output register.
	bis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the bitmap, the running count and the result.
	bis_dp #(
		.WORD_COUNT (WORD_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.opcode       (opcode),
		.element      (element),
		.cmd          (cmd),
		.status       (status),
		.was_member   (was_member),
		.member_count (member_count),
		.out_of_range (out_of_range)
	);

endmodule

// File: design/bis_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/bis_ctrl.sv
// Controller state machine of the bitmap integer set.
// Depends on bis_pkg for the command and status structs.
`timescale 1ns / 1ps

module bis_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  bis_pkg::bis_status_t status,
	output bis_pkg::bis_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_SWEEP,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_step = 1'b1;
			end
			ST_IDLE: begin
				cmd.accept      = in_valid;
				cmd.sweep_start = in_valid && status.in_is_clear;
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
			end
			ST_EXEC: begin
				cmd.commit = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (status.sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= status.in_is_clear ? ST_SWEEP : ST_EXEC;
					end
				end
				ST_SWEEP: begin
					if (status.sweep_last) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// A result only appears out of the execute state.
	a_rise_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("result appeared outside the execute state");

	// A pending operation commits as soon as the receiver is not stalling.
	a_exec_commits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && !out_stall) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("execute state did not commit");

	// A clear never lets a new input in before its sweep has finished.
	a_sweep_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && !status.sweep_last) |=> in_stall)
		else $error("input accepted during clearing sweep");

endmodule

// File: design/bis_dp.sv
// Datapath of the bitmap integer set: bitmap RAM, clearing address,
// running member count and result register.
// Depends on bis_pkg and bis_ram.
`timescale 1ns / 1ps

module bis_dp #(
	parameter int WORD_COUNT = bis_pkg::WORD_COUNT_DEFAULT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [bis_pkg::OP_W-1:0]         opcode,
	input  logic [bis_pkg::ELEM_W-1:0]       element,
	input  bis_pkg::bis_cmd_t                cmd,
	output bis_pkg::bis_status_t             status,
	output logic                             was_member,
	output logic [bis_pkg::COUNT_W-1:0]      member_count,
	output logic                             out_of_range
);

	localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam logic [bis_pkg::WORD_IDX_W:0] WORD_LIMIT =
		(bis_pkg::WORD_IDX_W + 1)'(WORD_COUNT);
	localparam logic [AW-1:0] LAST_ADDR = AW'(WORD_COUNT - 1);

	bis_pkg::bis_op_t                 op_q;
	logic [bis_pkg::ELEM_W-1:0]       elem_q;
	logic [AW-1:0]                    sweep_addr_q;
	logic [bis_pkg::COUNT_W-1:0]      count_q;
	logic [bis_pkg::COUNT_W-1:0]      count_next;

	logic [bis_pkg::WORD_W-1:0]       rdata;
	logic [bis_pkg::WORD_W-1:0]       wdata;
	logic [bis_pkg::WORD_W-1:0]       bit_mask;
	logic [AW-1:0]                    waddr;
	logic                             we;
	logic                             oor;
	logic                             hit;
	logic                             do_set;
	logic                             do_reset;

	logic                             was_member_q;
	logic [bis_pkg::COUNT_W-1:0]      member_count_q;
	logic                             out_of_range_q;

	bis_ram #(
		.WIDTH (bis_pkg::WORD_W),
		.DEPTH (WORD_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.accept),
		.raddr (element[bis_pkg::BIT_SEL_W +: AW]),
		.rdata (rdata)
	);

	assign status.in_is_clear = (bis_pkg::bis_op_t'(opcode) == bis_pkg::OP_CLEAR);
	assign status.sweep_last  = (sweep_addr_q == LAST_ADDR);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= bis_pkg::bis_op_t'(opcode);
			elem_q <= element;
		end
	end

	// The clearing address is control state: it drives the sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_addr_q <= '0;
		end else if (cmd.sweep_start) begin
			sweep_addr_q <= '0;
		end else if (cmd.sweep_step) begin
			sweep_addr_q <= sweep_addr_q + AW'(1);
		end
	end

	assign bit_mask = bis_pkg::WORD_W'(1) << elem_q[bis_pkg::BIT_SEL_W-1:0];
	assign oor = (op_q != bis_pkg::OP_CLEAR) &&
		({1'b0, elem_q[bis_pkg::ELEM_W-1:bis_pkg::BIT_SEL_W]} >= WORD_LIMIT);
	assign hit = (op_q != bis_pkg::OP_CLEAR) && !oor && ((rdata & bit_mask) != '0);
	assign do_set   = (op_q == bis_pkg::OP_ADD) && !oor && !hit;
	assign do_reset = (op_q == bis_pkg::OP_REMOVE) && hit;

	always_comb begin
		case (op_q)
			bis_pkg::OP_CLEAR:  count_next = '0;
			bis_pkg::OP_ADD:    count_next = do_set ? count_q + 1'b1 : count_q;
			bis_pkg::OP_REMOVE: count_next = do_reset ? count_q - 1'b1 : count_q;
			default:            count_next = count_q;
		endcase
	end

	assign we    = cmd.sweep_step || (cmd.commit && (do_set || do_reset));
	assign waddr = cmd.sweep_step ? sweep_addr_q : elem_q[bis_pkg::BIT_SEL_W +: AW];
	assign wdata = cmd.sweep_step ? '0 :
		(do_set ? (rdata | bit_mask) : (rdata & ~bit_mask));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			was_member_q   <= hit;
			member_count_q <= count_next;
			out_of_range_q <= oor;
		end
	end

	assign was_member   = was_member_q;
	assign member_count = member_count_q;
	assign out_of_range = out_of_range_q;

	// A clear always reports an empty set.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && op_q == bis_pkg::OP_CLEAR) |=> (member_count_q == '0 && count_q == '0))
		else $error("clear did not empty the set");

	// An element beyond capacity leaves the count alone and is never a member.
	a_oor_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && oor) |=> (count_q == $past(count_q) && !was_member_q))
		else $error("out of range element changed the set");

	// The sweep and a write back never compete for the write port.
	a_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_step |-> !cmd.commit)
		else $error("sweep and commit in the same cycle");

endmodule

// File: tb/bis_checker.sv
// Scoreboard for the bitmap integer set. It keeps a shadow bitmap and member
// count, predicts every result word, and compares it with what comes out.
// Depends on bis_pkg.
`timescale 1ns / 1ps

module bis_checker
	import bis_pkg::*;
#(
	parameter int WORD_COUNT = WORD_COUNT_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [OP_W-1:0]    opcode,
	input  logic [ELEM_W-1:0]  element,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               was_member,
	input  logic [COUNT_W-1:0] member_count,
	input  logic               out_of_range,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic               was_member;
		logic [COUNT_W-1:0] member_count;
		logic               out_of_range;
	} set_answer_t;

	logic [WORD_W-1:0]  shadow_words [WORD_COUNT];
	logic [COUNT_W-1:0] shadow_count;
	set_answer_t        awaited_answers [$];

	// Applies one operation to the shadow set and returns the answer it gives.
	function automatic set_answer_t apply_set_op(input bis_op_t op,
			input logic [ELEM_W-1:0] elem);
		set_answer_t       ans;
		int unsigned       idx;
		logic [WORD_W-1:0] mask;
		ans = '0;
		idx = elem >> BIT_SEL_W;
		mask = '0;
		mask[elem[BIT_SEL_W-1:0]] = 1'b1;
		if (op == OP_CLEAR) begin
			foreach (shadow_words[i])
				shadow_words[i] = '0;
			shadow_count = '0;
		end else if (idx >= WORD_COUNT) begin
			ans.out_of_range = 1'b1;
		end else begin
			ans.was_member = |(shadow_words[idx] & mask);
			if (op == OP_ADD && !ans.was_member) begin
				shadow_words[idx] = shadow_words[idx] | mask;
				shadow_count = shadow_count + 1'b1;
			end else if (op == OP_REMOVE && ans.was_member) begin
				shadow_words[idx] = shadow_words[idx] & ~mask;
				shadow_count = shadow_count - 1'b1;
			end
		end
		ans.member_count = shadow_count;
		return ans;
	endfunction

	task automatic note_fault(input string what, input set_answer_t want,
			input set_answer_t seen);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t bis_checker: %s: expected was_member=%0b count=%0d oor=%0b,%s",
				$realtime, what, want.was_member, want.member_count, want.out_of_range,
				$sformatf(" got was_member=%0b count=%0d oor=%0b",
					seen.was_member, seen.member_count, seen.out_of_range));
	endtask

	always @(posedge clk or negedge arst_n) begin
		set_answer_t want;
		set_answer_t seen;
		if (!arst_n) begin
			foreach (shadow_words[i])
				shadow_words[i] = '0;
			shadow_count = '0;
			awaited_answers.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// The result side goes first: a result can never belong to the word
			// taken at the same edge.
			if (out_valid && !out_stall) begin
				seen = {was_member, member_count, out_of_range};
				if (awaited_answers.size() == 0) begin
					note_fault("result word with nothing outstanding", '0, seen);
				end else begin
					want = awaited_answers.pop_front();
					if (seen.was_member !== want.was_member ||
							seen.member_count !== want.member_count ||
							seen.out_of_range !== want.out_of_range)
						note_fault("result word mismatch", want, seen);
				end
			end
			if (in_valid && !in_stall)
				awaited_answers.push_back(apply_set_op(bis_op_t'(opcode), element));
			pending = awaited_answers.size();
		end
	end

endmodule

// File: tb/tb_bitmap_integer_set.sv
// Testbench top for the bitmap integer set: drives operation words, random
// result stalls and the reset, and gives the verdict.
// Depends on bis_pkg, bitmap_integer_set and bis_checker.
`timescale 1ns / 1ps

module tb_bitmap_integer_set;
	import bis_pkg::*;

	localparam int WORDS    = WORD_COUNT_DEFAULT;
	localparam int CAPACITY = WORDS * WORD_W;
	// Span of elements that one random phase works on. It is kept small so
	// that adds, removes and tests keep landing on the same members.
	localparam int WINDOW   = 96;
	// Cycles with no handshake on either side before the run is declared hung.
	// The slowest honest gap is a clear stacked on a full stall burst and a
	// full sender gap, so this is many times that.
	localparam int HANG_LIMIT   = 4000;
	// Quiet cycles after the last result, to catch any stray extra word.
	localparam int DRAIN_CYCLES = 8;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [OP_W-1:0]    opcode = OP_TEST;
	logic [ELEM_W-1:0]  element = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               was_member;
	logic [COUNT_W-1:0] member_count;
	logic               out_of_range;

	int fail_count;
	int pending;
	// Chance in percent that an idle burst starts: per cycle for the receiver,
	// per word for the sender. Zero turns idling off; the last phase of the run keeps it at zero.
	int idle_pct = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bitmap_integer_set #(
		.WORD_COUNT(WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.element(element),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.was_member(was_member),
		.member_count(member_count),
		.out_of_range(out_of_range)
	);

	bis_checker #(
		.WORD_COUNT(WORDS)
	) set_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.element(element),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.was_member(was_member),
		.member_count(member_count),
		.out_of_range(out_of_range),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Receiver back-pressure. A burst holds out_stall high until its random
	// countdown in stall_left runs out; a burst already under way runs out even after idling is switched off.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(99) < idle_pct) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(13);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Hang detection: count cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("tb_bitmap_integer_set NOT OK");
				$finish;
			end
		end
	end

	// Offers one word and returns at the falling edge after it was taken.
	// The word stays on the pins, valid high, for as long as in_stall holds it
	// off. A gap with valid low, of a length drawn at random, may come first.
	task automatic send_word(input bis_op_t op, input logic [ELEM_W-1:0] elem);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(14, 1);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		element  <= elem;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		@(negedge clk);
	endtask

	initial begin
		bis_op_t           op;
		logic [ELEM_W-1:0] elem;
		int                roll;
		int                base;
		int                items;
		int                add_pct;

		// Reset is asserted once at the start and released on a falling edge.
		// The block then clears its store with in_stall high; the handshake in
		// send_word simply waits that out.
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed words: the empty set, duplicate add and remove of an absent
		// member, word and capacity boundaries, elements past capacity for all
		// three element operations (all-ones element among them), and clears of a
		// populated and of an emptied set, with either element extreme.
		send_word(OP_TEST,   16'd0);
		send_word(OP_ADD,    16'd0);
		send_word(OP_ADD,    16'd0);
		send_word(OP_TEST,   16'd0);
		send_word(OP_ADD,    16'd31);
		send_word(OP_ADD,    16'd32);
		send_word(OP_ADD,    ELEM_W'(CAPACITY - 1));
		send_word(OP_ADD,    ELEM_W'(CAPACITY));
		send_word(OP_TEST,   ELEM_W'(CAPACITY));
		send_word(OP_REMOVE, ELEM_W'(CAPACITY));
		send_word(OP_ADD,    16'hffff);
		send_word(OP_TEST,   16'hffff);
		send_word(OP_REMOVE, 16'hffff);
		send_word(OP_REMOVE, 16'd32);
		send_word(OP_REMOVE, 16'd32);
		send_word(OP_TEST,   16'd31);
		send_word(OP_ADD,    16'h0aaa);
		send_word(OP_ADD,    16'h0555);
		send_word(OP_CLEAR,  16'hffff);
		send_word(OP_TEST,   16'd0);
		send_word(OP_ADD,    ELEM_W'(CAPACITY - 1));
		send_word(OP_REMOVE, ELEM_W'(CAPACITY - 1));
		send_word(OP_CLEAR,  16'd0);
		send_word(OP_TEST,   ELEM_W'(CAPACITY - 1));

		// Random phases. Each phase works mostly inside a small window of
		// elements at a random place in the bitmap, so members build up and
		// get removed again; the rest are elements from the whole capacity
		// and elements past it, which exercise every element bit. Even phases
		// lean toward adds and odd ones toward removes, so the count climbs
		// and falls. Clears are rare because each one sweeps the whole store.
		for (int phase = 0; phase < 9; phase++) begin
			base = $urandom_range(CAPACITY - WINDOW);
			add_pct = (phase % 2 == 0) ? 75 : 50;
			if (phase == 8) begin
				// Final stretch runs flat out on both sides.
				idle_pct = 0;
				items = 50;
			end else begin
				roll = $urandom_range(2);
				idle_pct = (roll == 0) ? 0 : (roll == 1) ? 8 : 30;
				items = 75;
			end
			for (int n = 0; n < items; n++) begin
				roll = $urandom_range(99);
				if (roll < 2)
					op = OP_CLEAR;
				else if (roll < 30)
					op = OP_TEST;
				else if (roll < add_pct)
					op = OP_ADD;
				else
					op = OP_REMOVE;
				roll = $urandom_range(99);
				if (roll < 75)
					elem = ELEM_W'(base + $urandom_range(WINDOW - 1));
				else if (roll < 88)
					elem = ELEM_W'($urandom_range(CAPACITY - 1));
				else
					elem = ELEM_W'($urandom_range(65535, CAPACITY));
				send_word(op, elem);
			end
			// Between phases the sender holds off until every result is back,
			// so the block also sees words arriving at a fully idle pipeline.
			if (phase != 8) begin
				in_valid <= 1'b0;
				do
					@(negedge clk);
				while (pending != 0);
			end
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("tb_bitmap_integer_set OK");
		else
			$display("tb_bitmap_integer_set NOT OK");
		$finish;
	end

endmodule

// File: files.f
design/bis_pkg.sv
design/bis_ram.sv
design/bis_ctrl.sv
design/bis_dp.sv
design/bitmap_integer_set.sv
tb/bis_checker.sv
tb/tb_bitmap_integer_set.sv
